// ----- rtl/pbm_pkg.sv -----
// pbm_pkg: shared types and constants for the pixel blend with mask block
// no dependencies; used by pbm_div_stage, pbm_lane and pixel_blend_with_mask
`default_nettype none

package pbm_pkg;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_DIFF = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_MUL  = 3'd4;
    localparam logic [2:0] MODE_SRC  = 3'd5;

    // register map, index taken from paddr[2]
    localparam logic REG_BLEND_MODE = 1'b0;
    localparam logic REG_USE_MASK   = 1'b1;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // divide quotient width and saturation level
    localparam int DIV_Q_BITS = 16;
    localparam int DIV_SAT    = 65535;

    // input reg, prep, divider stages, select, products, sum, clamp
    localparam int LANE_STAGES = DIV_Q_BITS + 6;
    localparam int PIPE_STAGES = LANE_STAGES + 1;

    typedef struct packed {
        logic [2:0] blend_mode;
        logic       use_mask;
    } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/pbm_div_stage.sv -----
// pbm_div_stage: one registered restoring-division step, one quotient bit
// depends on pbm_pkg
`default_nettype none

module pbm_div_stage #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              en,
    input  wire logic [CHANNEL_BITS-1:0]           divisor,
    input  wire logic [CHANNEL_BITS-1:0]           rem_in,
    input  wire logic [pbm_pkg::DIV_Q_BITS-1:0]    nq_in,
    output logic      [CHANNEL_BITS-1:0]           rem_out,
    output logic      [pbm_pkg::DIV_Q_BITS-1:0]    nq_out
);

    localparam int CB = CHANNEL_BITS;
    localparam int QB = pbm_pkg::DIV_Q_BITS;

    logic [CB:0]   rr;
    logic [CB:0]   diff;
    logic          ge;
    logic [CB-1:0] rem_reg;
    logic [QB-1:0] nq_reg;

    always_comb
    begin
        rr   = {rem_in, nq_in[QB-1]};
        ge   = (rr >= {1'b0, divisor});
        diff = rr - {1'b0, divisor};
    end

    // numerator bits leave at the top, quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= ge ? diff[CB-1:0] : rr[CB-1:0];
            nq_reg  <= {nq_in[QB-2:0], ge};
        end
    end

    assign rem_out = rem_reg;
    assign nq_out  = nq_reg;

endmodule

`default_nettype wire

// ----- rtl/pbm_lane.sv -----
// pbm_lane: pipelined blend of one color channel (mode value, mask mix, clamp)
// depends on pbm_pkg and pbm_div_stage
`default_nettype none

module pbm_lane #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                clk,
    input  wire logic [pbm_pkg::LANE_STAGES-1:0]     adv,
    input  wire pbm_pkg::cfg_t                       cfg,
    input  wire logic [CHANNEL_BITS-1:0]             src,
    input  wire logic [CHANNEL_BITS-1:0]             dst,
    input  wire logic [CHANNEL_BITS-1:0]             mask,
    output logic      [CHANNEL_BITS-1:0]             result
);

    localparam int CB      = CHANNEL_BITS;
    localparam int QB      = pbm_pkg::DIV_Q_BITS;
    localparam int NXW     = CB + QB;
    localparam int VW      = (CB + 2 > QB + 1) ? CB + 2 : QB + 1;
    localparam int PW      = VW + CB + 1;
    localparam int TW      = VW + CB + 2;
    localparam int SEL_ST  = QB + 2;
    localparam int MUL_ST  = SEL_ST + 1;
    localparam int SUM_ST  = MUL_ST + 1;
    localparam int OUT_ST  = SUM_ST + 1;

    localparam longint MAXV_L = (64'sd1 <<< CB) - 64'sd1;
    localparam logic [CB-1:0]        MAXV    = CB'(MAXV_L);
    localparam logic [CB-1:0]        HALF    = CB'(MAXV_L >>> 1);
    localparam logic signed [VW-1:0] MAXV_V  = VW'(MAXV_L);
    localparam logic signed [VW-1:0] SAT_V   = VW'(pbm_pkg::DIV_SAT);
    localparam logic signed [TW-1:0] MAXSQ   = TW'(MAXV_L * MAXV_L);
    localparam logic signed [TW-1:0] HALF_T  = TW'(MAXV_L >>> 1);

    // operand taps along the pipeline
    logic [CB-1:0]   s_pipe    [0:SEL_ST-1];
    logic [CB-1:0]   d_pipe    [0:MUL_ST-1];
    logic [CB-1:0]   m_pipe    [0:MUL_ST-1];
    logic            sat_pipe  [1:SEL_ST-1];
    logic            zero_pipe [1:SEL_ST-1];
    logic [2*CB-1:0] prod_pipe [1:SEL_ST-1];

    logic [CB-1:0]   rem_w [0:QB];
    logic [QB-1:0]   nq_w  [0:QB];
    logic [CB-1:0]   rem1_reg;
    logic [QB-1:0]   nq1_reg;

    logic [2*CB-1:0] num_c;
    logic [NXW-1:0]  num_x;
    logic [NXW-1:0]  scaled_c;
    logic            sat_c;
    logic            zero_c;
    logic [2*CB-1:0] prod_c;

    logic signed [VW-1:0] sv_c;
    logic signed [VW-1:0] dv_c;
    logic [2*CB-1:0]      mul_sum;
    logic signed [VW-1:0] v_c;
    logic signed [VW-1:0] v18_reg;

    logic [2*CB-1:0]      p1_c;
    logic signed [PW-1:0] p2_c;
    logic [2*CB-1:0]      p1_reg;
    logic signed [PW-1:0] p2_reg;
    logic signed [VW-1:0] v19_reg;

    logic signed [TW-1:0] t_c;
    logic signed [TW-1:0] t_reg;
    logic signed [VW-1:0] v20_reg;

    logic [2*CB-1:0]      q_sum;
    logic [CB-1:0]        res_c;
    logic [CB-1:0]        res_reg;

    // stage 0: input capture
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            s_pipe[0] <= src;
            d_pipe[0] <= dst;
            m_pipe[0] <= mask;
        end
    end

    // stage 1: divide setup, saturation test and multiply product
    always_comb
    begin
        num_c    = {d_pipe[0], {CB{1'b0}}} - {{CB{1'b0}}, d_pipe[0]};
        num_x    = NXW'(num_c);
        scaled_c = {s_pipe[0], {QB{1'b0}}};
        zero_c   = (s_pipe[0] == '0) && (d_pipe[0] == '0);
        if (s_pipe[0] == '0)
        begin
            sat_c = (d_pipe[0] != '0);
        end
        else
        begin
            sat_c = (num_x >= scaled_c);
        end
        prod_c = {{CB{1'b0}}, d_pipe[0]} * {{CB{1'b0}}, s_pipe[0]}
               + {{CB{1'b0}}, HALF};
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s_pipe[1]    <= s_pipe[0];
            d_pipe[1]    <= d_pipe[0];
            m_pipe[1]    <= m_pipe[0];
            sat_pipe[1]  <= sat_c;
            zero_pipe[1] <= zero_c;
            prod_pipe[1] <= prod_c;
            rem1_reg     <= num_x[NXW-1:QB];
            nq1_reg      <= num_x[QB-1:0];
        end
    end

    assign rem_w[0] = rem1_reg;
    assign nq_w[0]  = nq1_reg;

    // divider stages with operands riding alongside
    for (genvar k = 0; k < QB; k++)
    begin : g_div
        pbm_div_stage #(
            .CHANNEL_BITS(CB)
        ) u_div_stage (
            .clk    (clk),
            .en     (adv[k+2]),
            .divisor(s_pipe[k+1]),
            .rem_in (rem_w[k]),
            .nq_in  (nq_w[k]),
            .rem_out(rem_w[k+1]),
            .nq_out (nq_w[k+1])
        );

        always_ff @(posedge clk)
        begin
            if (adv[k+2])
            begin
                s_pipe[k+2]    <= s_pipe[k+1];
                d_pipe[k+2]    <= d_pipe[k+1];
                m_pipe[k+2]    <= m_pipe[k+1];
                sat_pipe[k+2]  <= sat_pipe[k+1];
                zero_pipe[k+2] <= zero_pipe[k+1];
                prod_pipe[k+2] <= prod_pipe[k+1];
            end
        end
    end

    // select the mode value
    always_comb
    begin
        sv_c    = $signed({{(VW-CB){1'b0}}, s_pipe[SEL_ST-1]});
        dv_c    = $signed({{(VW-CB){1'b0}}, d_pipe[SEL_ST-1]});
        mul_sum = prod_pipe[SEL_ST-1]
                + {{CB{1'b0}}, prod_pipe[SEL_ST-1][2*CB-1:CB]}
                + {{(2*CB-1){1'b0}}, 1'b1};
        unique case (cfg.blend_mode)
            pbm_pkg::MODE_ADD:
            begin
                v_c = dv_c + sv_c;
            end
            pbm_pkg::MODE_SUB:
            begin
                v_c = dv_c - sv_c;
            end
            pbm_pkg::MODE_DIFF:
            begin
                v_c = (dv_c >= sv_c) ? (dv_c - sv_c) : (sv_c - dv_c);
            end
            pbm_pkg::MODE_DIV:
            begin
                if (zero_pipe[SEL_ST-1])
                begin
                    v_c = '0;
                end
                else if (sat_pipe[SEL_ST-1])
                begin
                    v_c = SAT_V;
                end
                else
                begin
                    v_c = $signed({{(VW-QB){1'b0}}, nq_w[QB]});
                end
            end
            pbm_pkg::MODE_MUL:
            begin
                v_c = $signed({{(VW-CB){1'b0}}, mul_sum[2*CB-1:CB]});
            end
            default:
            begin
                v_c = sv_c;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[SEL_ST])
        begin
            v18_reg        <= v_c;
            d_pipe[SEL_ST] <= d_pipe[SEL_ST-1];
            m_pipe[SEL_ST] <= m_pipe[SEL_ST-1];
        end
    end

    // mask products
    always_comb
    begin
        p1_c = {{CB{1'b0}}, d_pipe[SEL_ST]} * {{CB{1'b0}}, (MAXV - m_pipe[SEL_ST])};
        p2_c = PW'(v18_reg) * $signed({{(PW-CB){1'b0}}, m_pipe[SEL_ST]});
    end

    always_ff @(posedge clk)
    begin
        if (adv[MUL_ST])
        begin
            p1_reg  <= p1_c;
            p2_reg  <= p2_c;
            v19_reg <= v18_reg;
        end
    end

    // mix numerator
    always_comb
    begin
        t_c = $signed({{(TW-2*CB){1'b0}}, p1_reg})
            + $signed({{(TW-PW){p2_reg[PW-1]}}, p2_reg})
            + HALF_T;
    end

    always_ff @(posedge clk)
    begin
        if (adv[SUM_ST])
        begin
            t_reg   <= t_c;
            v20_reg <= v19_reg;
        end
    end

    // with the mask on, floor divide by the full-scale value; clamp in both cases
    always_comb
    begin
        q_sum = t_reg[2*CB-1:0]
              + {{CB{1'b0}}, t_reg[2*CB-1:CB]}
              + {{(2*CB-1){1'b0}}, 1'b1};
        if (cfg.use_mask)
        begin
            if (t_reg[TW-1])
            begin
                res_c = '0;
            end
            else if (t_reg >= MAXSQ)
            begin
                res_c = MAXV;
            end
            else
            begin
                res_c = q_sum[2*CB-1:CB];
            end
        end
        else
        begin
            if (v20_reg[VW-1])
            begin
                res_c = '0;
            end
            else if (v20_reg > MAXV_V)
            begin
                res_c = MAXV;
            end
            else
            begin
                res_c = v20_reg[CB-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[OUT_ST])
        begin
            res_reg <= res_c;
        end
    end

    assign result = res_reg;

endmodule

`default_nettype wire

// ----- rtl/pixel_blend_with_mask.sv -----
// pixel_blend_with_mask: top level, three channel lanes, merge and output stage
// depends on pbm_pkg and pbm_lane; apb register port for mode and mask enable
// an input word passes every lane stage and then the merge register before its output
// word can be accepted
// throughput: one pixel per cycle while the output is not stalled; every stage is pipelined,
// the 16-step divide included; a stalled output lets upstream stages keep filling bubbles
// reset clears the stage valid flags and both registers; data registers are not reset
`default_nettype none

module pixel_blend_with_mask #(
    parameter int CHANNEL_BITS = 8
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // src r, g, b, dst r, g, b, mask level; zero padded to bytes
    input  wire logic [((7*CHANNEL_BITS+7)/8)*8-1:0]       s_tdata,
    input  wire logic                                      s_tvalid,
    output logic                                           s_tready,
    // out r, g, b; zero padded to bytes
    output logic      [((3*CHANNEL_BITS+7)/8)*8-1:0]       m_tdata,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    input  wire logic                                      psel,
    input  wire logic                                      penable,
    input  wire logic                                      pwrite,
    input  wire logic [pbm_pkg::ADDR_W-1:0]                paddr,
    input  wire logic [pbm_pkg::DATA_W-1:0]                pwdata,
    output logic      [pbm_pkg::DATA_W-1:0]                prdata,
    output logic                                           pready
);

    localparam int CB = CHANNEL_BITS;
    localparam int OW = ((3*CHANNEL_BITS+7)/8)*8;
    localparam int PS = pbm_pkg::PIPE_STAGES;
    localparam int LS = pbm_pkg::LANE_STAGES;
    localparam logic [CB-1:0] MAXV = '1;

    logic [2:0]     mode_reg;
    logic           use_mask_reg;
    pbm_pkg::cfg_t  cfg;
    logic           cfg_wr;

    logic [PS-1:0]  valid_reg;
    logic [PS-1:0]  valid_next;
    logic [PS-1:0]  adv;

    logic [CB-1:0]  lane_res [0:2];
    logic [CB-1:0]  out_reg  [0:2];

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= pbm_pkg::MODE_ADD;
            use_mask_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == pbm_pkg::REG_BLEND_MODE)
            begin
                mode_reg <= pwdata[2:0];
            end
            else
            begin
                use_mask_reg <= pwdata[0];
            end
        end
    end

    always_comb
    begin
        if (paddr[2] == pbm_pkg::REG_USE_MASK)
        begin
            prdata = {{(pbm_pkg::DATA_W-1){1'b0}}, use_mask_reg};
        end
        else
        begin
            prdata = {{(pbm_pkg::DATA_W-3){1'b0}}, mode_reg};
        end
    end

    assign cfg.blend_mode = mode_reg;
    assign cfg.use_mask   = use_mask_reg;

    // a stage may load unless it and every stage after it are full and the output stalls
    always_comb
    begin
        logic [PS-1:0] low_mask;
        for (int i = 0; i < PS; i++)
        begin
            low_mask = ~({PS{1'b1}} << i);
            adv[i]   = m_tready || !(&(valid_reg | low_mask));
        end
    end

    always_comb
    begin
        valid_next[0] = adv[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < PS; i++)
        begin
            valid_next[i] = adv[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = adv[0];
    assign m_tvalid = valid_reg[PS-1];

    // channel lanes
    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        pbm_lane #(
            .CHANNEL_BITS(CB)
        ) u_lane (
            .clk   (clk),
            .adv   (adv[LS-1:0]),
            .cfg   (cfg),
            .src   (s_tdata[c*CB +: CB]),
            .dst   (s_tdata[(c+3)*CB +: CB]),
            .mask  (s_tdata[6*CB +: CB]),
            .result(lane_res[c])
        );
    end

    // merge: unused modes give full red
    always_ff @(posedge clk)
    begin
        if (adv[PS-1])
        begin
            if (mode_reg > pbm_pkg::MODE_SRC)
            begin
                out_reg[0] <= MAXV;
                out_reg[1] <= '0;
                out_reg[2] <= '0;
            end
            else
            begin
                out_reg[0] <= lane_res[0];
                out_reg[1] <= lane_res[1];
                out_reg[2] <= lane_res[2];
            end
        end
    end

    assign m_tdata = OW'({out_reg[2], out_reg[1], out_reg[0]});

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for pixel_blend_with_mask, blend result predicted per pixel
// depends on pbm_pkg and the rtl; apb writes set mode and mask, stream ports carry pixels
// directed corner cases first, then random pixels under every mode and mask setting
`default_nettype none

module tb_top;

    localparam int CH_BITS = 8;
    localparam longint CH_MAX = (1 << CH_BITS) - 1;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [pbm_pkg::ADDR_W-1:0] ADDR_BLEND_MODE = {pbm_pkg::REG_BLEND_MODE, 2'b00};
    localparam logic [pbm_pkg::ADDR_W-1:0] ADDR_USE_MASK = {pbm_pkg::REG_USE_MASK, 2'b00};
    localparam int DRAIN_CYCLES = pbm_pkg::PIPE_STAGES + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEMS_PER_SETTING = 90;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [CH_BITS-1:0] mask;
        logic [CH_BITS-1:0] dst_b;
        logic [CH_BITS-1:0] dst_g;
        logic [CH_BITS-1:0] dst_r;
        logic [CH_BITS-1:0] src_b;
        logic [CH_BITS-1:0] src_g;
        logic [CH_BITS-1:0] src_r;
    } pixel_word_t;

    typedef struct packed {
        logic [CH_BITS-1:0] blue;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] red;
    } rgb_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic [55:0] s_tdata = '0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [23:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [pbm_pkg::ADDR_W-1:0] paddr = '0;
    logic [pbm_pkg::DATA_W-1:0] pwdata = '0;
    logic [pbm_pkg::DATA_W-1:0] prdata;
    logic pready;

    pbm_pkg::cfg_t blend_cfg = '0;
    rgb_t expected_pixels[$];
    rgb_t want;
    rgb_t got;
    int error_count = 0;
    int idle_cycles = 0;
    int burst_left = 0;
    bit sender_gaps_on = 1'b1;
    bit rx_stall_on = 1'b1;
    logic [31:0] stall_pattern = 32'h1;
    logic [4:0] stall_slot = '0;

    pixel_blend_with_mask #(
        .CHANNEL_BITS(CH_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [CH_BITS-1:0] blend_channel(
        logic [CH_BITS-1:0] s, logic [CH_BITS-1:0] d, logic [CH_BITS-1:0] m,
        pbm_pkg::cfg_t c);
        longint sv;
        longint dv;
        longint mv;
        longint v;
        longint num;
        sv = s;
        dv = d;
        mv = m;
        case (c.blend_mode)
            pbm_pkg::MODE_ADD:  v = dv + sv;
            pbm_pkg::MODE_SUB:  v = dv - sv;
            pbm_pkg::MODE_DIFF: v = (dv >= sv) ? dv - sv : sv - dv;
            pbm_pkg::MODE_DIV:
            begin
                if (sv == 0)
                    v = (dv > 0) ? pbm_pkg::DIV_SAT : 0;
                else
                begin
                    v = (dv * CH_MAX) / sv;
                    if (v > pbm_pkg::DIV_SAT)
                        v = pbm_pkg::DIV_SAT;
                end
            end
            pbm_pkg::MODE_MUL:  v = (dv * sv + CH_MAX / 2) / CH_MAX;
            default:            v = sv;
        endcase
        if (c.use_mask)
        begin
            num = dv * (CH_MAX - mv) + v * mv + CH_MAX / 2;
            // floor division, negative sums round down
            v = (num >= 0) ? num / CH_MAX : -((-num + CH_MAX - 1) / CH_MAX);
        end
        if (v < 0)
            v = 0;
        if (v > CH_MAX)
            v = CH_MAX;
        return v[CH_BITS-1:0];
    endfunction

    function automatic rgb_t blend_pixel(pixel_word_t p, pbm_pkg::cfg_t c);
        rgb_t r;
        if (c.blend_mode > pbm_pkg::MODE_SRC)
        begin
            r.red = CH_MAX[CH_BITS-1:0];
            r.green = '0;
            r.blue = '0;
        end
        else
        begin
            r.red = blend_channel(p.src_r, p.dst_r, p.mask, c);
            r.green = blend_channel(p.src_g, p.dst_g, p.mask, c);
            r.blue = blend_channel(p.src_b, p.dst_b, p.mask, c);
        end
        return r;
    endfunction

    function automatic pixel_word_t make_pixel(int sr, int sg, int sb, int dr, int dg, int db,
        int m);
        pixel_word_t p;
        p.src_r = CH_BITS'(sr);
        p.src_g = CH_BITS'(sg);
        p.src_b = CH_BITS'(sb);
        p.dst_r = CH_BITS'(dr);
        p.dst_g = CH_BITS'(dg);
        p.dst_b = CH_BITS'(db);
        p.mask = CH_BITS'(m);
        return p;
    endfunction

    function automatic logic [CH_BITS-1:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_MAX[CH_BITS-1:0];
            2:       return CH_BITS'($urandom_range(0, 3));
            3:       return CH_BITS'($urandom_range(CH_MAX - 3, CH_MAX));
            default: return CH_BITS'($urandom_range(0, CH_MAX));
        endcase
    endfunction

    function automatic pixel_word_t random_pixel();
        return pixel_word_t'({pick_level(), pick_level(), pick_level(), pick_level(),
            pick_level(), pick_level(), pick_level()});
    endfunction

    // receiver stall pattern, bit 0 forced so stalls stay bounded
    always @(negedge clk)
    begin
        if (stall_slot == 0)
            stall_pattern <= $urandom | 32'h1;
        stall_slot <= stall_slot + 1'b1;
        m_tready <= !rx_stall_on || stall_pattern[stall_slot];
    end

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            expected_pixels.push_back(blend_pixel(s_tdata, blend_cfg));
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                    $display("unexpected output word r=%0d g=%0d b=%0d",
                        got.red, got.green, got.blue);
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green
                    || got.blue !== want.blue)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                        $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                            want.red, want.green, want.blue, got.red, got.green, got.blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // called and returns at a falling edge, tvalid left high
    task automatic send_pixel(pixel_word_t p);
        if (burst_left == 0)
        begin
            if (sender_gaps_on)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tdata = p;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic drain_outputs();
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic reg_write(logic [pbm_pkg::ADDR_W-1:0] addr,
        logic [pbm_pkg::DATA_W-1:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (addr == ADDR_BLEND_MODE)
            blend_cfg.blend_mode = value[2:0];
        else if (addr == ADDR_USE_MASK)
            blend_cfg.use_mask = value[0];
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // upper register bits carry noise, the block keeps only the field
    task automatic set_config(logic [2:0] mode, logic mask_on);
        drain_outputs();
        reg_write(ADDR_BLEND_MODE, ($urandom << 3) | mode);
        reg_write(ADDR_USE_MASK, ($urandom << 1) | mask_on);
        @(negedge clk);
    endtask

    task automatic test_reset_state();
        send_pixel(make_pixel(255, 128, 0, 255, 200, 0, 0));
        send_pixel(make_pixel(1, 0, 255, 0, 0, 255, 255));
    endtask

    task automatic test_mode_extremes();
        for (int k = pbm_pkg::MODE_ADD; k <= pbm_pkg::MODE_SRC; k++)
        begin
            set_config(3'(k), 1'b0);
            send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0));
            send_pixel(make_pixel(255, 0, 1, 255, 255, 0, 128));
        end
    endtask

    task automatic test_divide_by_zero();
        set_config(pbm_pkg::MODE_DIV, 1'b1);
        send_pixel(make_pixel(0, 0, 1, 255, 0, 1, 255));
        send_pixel(make_pixel(0, 0, 0, 1, 0, 200, 128));
    endtask

    task automatic test_unused_modes();
        set_config(MODE_UNUSED_LO, 1'b1);
        send_pixel(make_pixel(17, 200, 3, 90, 255, 0, 255));
        set_config(MODE_UNUSED_HI, 1'b1);
        send_pixel(make_pixel(255, 255, 255, 255, 255, 255, 0));
    endtask

    task automatic test_mask_mix();
        set_config(pbm_pkg::MODE_SUB, 1'b1);
        send_pixel(make_pixel(255, 255, 0, 0, 0, 255, 255));
        send_pixel(make_pixel(255, 10, 0, 0, 200, 255, 0));
        send_pixel(make_pixel(200, 100, 1, 3, 150, 254, 77));
    endtask

    task automatic test_random_blends();
        for (int k = 0; k <= MODE_UNUSED_HI; k++)
        begin
            for (int mk = 0; mk <= 1; mk++)
            begin
                set_config(3'(k), 1'(mk));
                sender_gaps_on = ($urandom_range(0, 3) != 0);
                rx_stall_on = ($urandom_range(0, 3) != 0);
                repeat (ITEMS_PER_SETTING) send_pixel(random_pixel());
            end
        end
    endtask

    task automatic test_drain_pause();
        set_config(pbm_pkg::MODE_MUL, 1'b1);
        sender_gaps_on = 1'b0;
        rx_stall_on = 1'b1;
        repeat (30) send_pixel(random_pixel());
        s_tvalid = 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        @(negedge clk);
        repeat (30) send_pixel(random_pixel());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_state();
        test_mode_extremes();
        test_divide_by_zero();
        test_unused_modes();
        test_mask_mix();
        test_random_blends();
        test_drain_pause();
        drain_outputs();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
